FILE: src/orw_pkg.sv
package orw_pkg;

  // Address register width after post-increment (24 to 32)
  localparam int ADDR_BITS = 24;
  localparam logic [31:0] ADDR_MASK = 32'hffff_ffff >> (32 - ADDR_BITS);

  localparam logic [3:0] CYC_NONE     = 4'd0;
  localparam logic [3:0] CYC_MEM      = 4'd4;
  localparam logic [3:0] CYC_MEM_LONG = 4'd8;

  localparam logic [2:0] REG_SP = 3'd7;

  typedef enum logic [3:0] {
    MODE_DREG    = 4'd0,
    MODE_AREG    = 4'd1,
    MODE_IND     = 4'd2,
    MODE_POSTINC = 4'd3,
    MODE_PREDEC  = 4'd4,
    MODE_DISP    = 4'd5,
    MODE_ABSL    = 4'd6,
    MODE_IMM     = 4'd7,
    MODE_OTHER   = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_t;

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_REG_DONE = 3'd1,
    KIND_BUS_BYTE = 3'd2,
    KIND_BUS_WORD = 3'd3,
    KIND_UNSUP    = 3'd4
  } kind_t;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  operand_mode;
    logic [2:0]  reg_index;
    logic [1:0]  op_size;
    logic [23:0] eff_address;
    logic [31:0] immediate;
    logic [31:0] store_value;
    logic [15:0] mem_first;
    logic [15:0] mem_second;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] bus_address;
    logic [15:0] bus_data;
    logic [31:0] read_value;
    logic [3:0]  cycles;
    logic        flag_n;
    logic        flag_z;
    logic        last;
  } result_t;

  // State updates of one item
  typedef struct packed {
    logic        d_we;
    logic [31:0] d_data;
    logic        a_we;
    logic [31:0] a_data;
    logic        flag_n;
    logic        flag_z;
  } wb_t;

endpackage

FILE: src/orw_if.sv
interface orw_in_if;
  import orw_pkg::*;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  operand_mode;
  logic [2:0]  reg_index;
  logic [1:0]  op_size;
  logic [23:0] eff_address;
  logic [31:0] immediate;
  logic [31:0] store_value;
  logic [15:0] mem_first;
  logic [15:0] mem_second;

  modport source (output valid, action, operand_mode, reg_index, op_size, eff_address,
                  immediate, store_value, mem_first, mem_second, input ready);
  modport sink (input valid, action, operand_mode, reg_index, op_size, eff_address,
                immediate, store_value, mem_first, mem_second, output ready);
endinterface

interface orw_out_if;
  import orw_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [23:0] bus_address;
  logic [15:0] bus_data;
  logic [31:0] read_value;
  logic [3:0]  cycles;
  logic        flag_n;
  logic        flag_z;
  logic        last;

  modport source (output valid, kind, bus_address, bus_data, read_value, cycles,
                  flag_n, flag_z, last, input ready);
  modport sink (input valid, kind, bus_address, bus_data, read_value, cycles,
                flag_n, flag_z, last, output ready);
endinterface

FILE: src/orw_exec.sv
module orw_exec (
  input  orw_pkg::in_item_t item,
  input  logic [31:0]       d_rd,
  input  logic [31:0]       a_rd,
  input  logic              flag_n,
  input  logic              flag_z,
  output orw_pkg::result_t  res0,
  output orw_pkg::result_t  res1,
  output logic              two,
  output orw_pkg::wb_t      wb
);
  import orw_pkg::*;

  logic        legal;
  logic [31:0] step;
  logic [31:0] inc_addr;
  logic [31:0] val;
  logic        n_new;
  logic        z_new;

  assign val = item.store_value;

  always_comb begin
    case (item.op_size)
      SZ_LONG: step = 32'd4;
      SZ_WORD: step = 32'd2;
      default: step = (item.reg_index == REG_SP) ? 32'd2 : 32'd1;
    endcase
    inc_addr = (a_rd + step) & ADDR_MASK;
  end

  always_comb begin
    legal = (item.op_size != 2'd3) &&
            (item.operand_mode inside {MODE_DREG, MODE_AREG, MODE_IND, MODE_POSTINC,
                                       MODE_DISP, MODE_ABSL, MODE_IMM}) &&
            !(item.action == ACT_WRITE && item.operand_mode == MODE_IMM);
  end

  always_comb begin
    res0      = '0;
    res0.kind = KIND_UNSUP;
    res0.last = 1'b1;
    res1      = '0;
    two       = 1'b0;
    wb        = '0;
    n_new     = flag_n;
    z_new     = flag_z;

    if (legal) begin
      if (item.action == ACT_READ) begin
        res0.kind = KIND_VALUE;
        case (item.operand_mode)
          MODE_DREG: res0.read_value = d_rd;
          MODE_AREG: res0.read_value = a_rd;
          MODE_IMM:  res0.read_value = item.immediate;
          default: begin
            case (item.op_size)
              SZ_BYTE: begin
                res0.read_value = {24'd0, item.mem_first[7:0]};
                res0.cycles     = CYC_MEM;
              end
              SZ_WORD: begin
                res0.read_value = {16'd0, item.mem_first};
                res0.cycles     = CYC_MEM;
              end
              default: begin
                res0.read_value = {item.mem_first, item.mem_second};
                res0.cycles     = CYC_MEM_LONG;
              end
            endcase
            if (item.operand_mode == MODE_POSTINC) begin
              wb.a_we   = 1'b1;
              wb.a_data = inc_addr;
            end
          end
        endcase
      end else begin
        case (item.operand_mode)
          MODE_DREG: begin
            res0.kind = KIND_REG_DONE;
            wb.d_we   = 1'b1;
            case (item.op_size)
              SZ_BYTE: begin
                n_new     = val[7];
                z_new     = (val[7:0] == 8'd0);
                wb.d_data = {d_rd[31:8], val[7:0]};
              end
              SZ_WORD: begin
                n_new     = val[15];
                z_new     = (val[15:0] == 16'd0);
                wb.d_data = {d_rd[31:16], val[15:0]};
              end
              default: begin
                n_new     = val[31];
                z_new     = (val == 32'd0);
                wb.d_data = val;
              end
            endcase
          end
          MODE_AREG: begin
            // byte writes to an address register are dropped
            res0.kind = KIND_REG_DONE;
            case (item.op_size)
              SZ_LONG: begin
                wb.a_we   = 1'b1;
                wb.a_data = val;
              end
              SZ_WORD: begin
                wb.a_we   = 1'b1;
                wb.a_data = {{16{val[15]}}, val[15:0]};
              end
              default: wb.a_we = 1'b0;
            endcase
          end
          default: begin
            res0.bus_address = item.eff_address;
            case (item.op_size)
              SZ_BYTE: begin
                res0.kind     = KIND_BUS_BYTE;
                res0.bus_data = {8'd0, val[7:0]};
                res0.cycles   = CYC_MEM;
                if (item.operand_mode != MODE_ABSL) begin
                  n_new = val[7];
                  z_new = (val[7:0] == 8'd0);
                end
              end
              SZ_WORD: begin
                res0.kind     = KIND_BUS_WORD;
                res0.bus_data = val[15:0];
                res0.cycles   = CYC_MEM;
                if (item.operand_mode != MODE_ABSL) begin
                  n_new = val[15];
                  z_new = (val[15:0] == 16'd0);
                end
              end
              default: begin
                // high half first, low half at address + 2
                res0.kind        = KIND_BUS_WORD;
                res0.bus_data    = val[31:16];
                res0.cycles      = CYC_MEM_LONG;
                res0.last        = 1'b0;
                res1.kind        = KIND_BUS_WORD;
                res1.bus_address = item.eff_address + 24'd2;
                res1.bus_data    = val[15:0];
                res1.cycles      = CYC_MEM_LONG;
                res1.last        = 1'b1;
                two              = 1'b1;
                if (item.operand_mode != MODE_ABSL) begin
                  n_new = val[31];
                  z_new = (val == 32'd0);
                end
              end
            endcase
            if (item.operand_mode == MODE_POSTINC) begin
              wb.a_we   = 1'b1;
              wb.a_data = inc_addr;
            end
          end
        endcase
      end
    end

    wb.flag_n   = n_new;
    wb.flag_z   = z_new;
    res0.flag_n = n_new;
    res0.flag_z = z_new;
    res1.flag_n = n_new;
    res1.flag_z = z_new;
  end

endmodule

FILE: src/operand_read_write_unit.sv
// Operand read/write unit.
// in_chan  : one transaction per operand access: action, mode, register, size,
//            effective address, immediate, store data and the memory words.
// out_chan : result transactions: operand value, register write done, bus
//            writes (byte/word) or unsupported. 'last' marks the final result
//            of an access; a long memory store gives two word writes.
// Path     : an input transaction passes the input register, then the result
//            register, before it shows on out_chan.valid.
// Rate     : one access per cycle while out_chan.ready is high; a long memory
//            store holds off the next access while its second bus write drains
//            through the single result register.
// Reset    : synchronous, active low. Clears all data and address registers,
//            both flags and all valid bits.
// Stall    : while out_chan.ready is low the result register and any pending
//            second bus write hold; the input register then holds and
//            in_chan.ready drops, so no transaction is lost.
module operand_read_write_unit (
  input logic        clk,
  input logic        rst_n,
  orw_in_if.sink     in_chan,
  orw_out_if.source  out_chan
);
  import orw_pkg::*;

  // register file and flags
  logic [31:0] data_regs_r [8];
  logic [31:0] addr_regs_r [8];
  logic        flag_n_r;
  logic        flag_z_r;

  // input stage
  logic        s_valid_r;
  in_item_t    s_item_r;

  // result register plus second-write holding register
  logic        out_valid_r;
  result_t     out_r;
  logic        sec_valid_r;
  result_t     sec_r;

  result_t     res0;
  result_t     res1;
  logic        two;
  wb_t         wb;
  logic        out_free;
  logic        advance;
  logic        in_take;

  orw_exec u_exec (
    .item   (s_item_r),
    .d_rd   (data_regs_r[s_item_r.reg_index]),
    .a_rd   (addr_regs_r[s_item_r.reg_index]),
    .flag_n (flag_n_r),
    .flag_z (flag_z_r),
    .res0   (res0),
    .res1   (res1),
    .two    (two),
    .wb     (wb)
  );

  // result slot opens when empty or being taken this cycle
  assign out_free = !out_valid_r || out_chan.ready;
  // stage moves only when no second write is queued behind the result register
  assign advance  = s_valid_r && out_free && !sec_valid_r;
  assign in_chan.ready = !s_valid_r || advance;
  assign in_take  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s_valid_r <= 1'b1;
      end else if (advance) begin
        s_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_item_r.action       <= in_chan.action;
      s_item_r.operand_mode <= in_chan.operand_mode;
      s_item_r.reg_index    <= in_chan.reg_index;
      s_item_r.op_size      <= in_chan.op_size;
      s_item_r.eff_address  <= in_chan.eff_address;
      s_item_r.immediate    <= in_chan.immediate;
      s_item_r.store_value  <= in_chan.store_value;
      s_item_r.mem_first    <= in_chan.mem_first;
      s_item_r.mem_second   <= in_chan.mem_second;
    end
  end

  // architectural state commits when the access leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        data_regs_r[i] <= '0;
        addr_regs_r[i] <= '0;
      end
      flag_n_r <= 1'b0;
      flag_z_r <= 1'b0;
    end else if (advance) begin
      if (wb.d_we) begin
        data_regs_r[s_item_r.reg_index] <= wb.d_data;
      end
      if (wb.a_we) begin
        addr_regs_r[s_item_r.reg_index] <= wb.a_data;
      end
      flag_n_r <= wb.flag_n;
      flag_z_r <= wb.flag_z;
    end
  end

  // output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (out_free) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else if (advance) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= two;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sec_valid_r) begin
        out_r <= sec_r;
      end else if (advance) begin
        out_r <= res0;
        sec_r <= res1;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_r.kind;
  assign out_chan.bus_address = out_r.bus_address;
  assign out_chan.bus_data    = out_r.bus_data;
  assign out_chan.read_value  = out_r.read_value;
  assign out_chan.cycles      = out_r.cycles;
  assign out_chan.flag_n      = out_r.flag_n;
  assign out_chan.flag_z      = out_r.flag_z;
  assign out_chan.last        = out_r.last;

endmodule

FILE: verif/operand_read_write_unit_tb.sv
`timescale 1ns / 1ps

module operand_read_write_unit_tb;
  import orw_pkg::*;

  // Idle patterns, one per stimulus phase
  localparam int PH_NONE     = 0;
  localparam int PH_SENDER   = 1;
  localparam int PH_RECEIVER = 2;
  localparam int PH_BOTH     = 3;

  localparam int SENDER_IDLE_PCT   = 88;
  localparam int RECEIVER_IDLE_PCT = 88;
  localparam int BOTH_IDLE_PCT     = 36;

  localparam int RANDOM_PER_PHASE = 225;
  localparam int HOLD_AFTER_ITEMS = 60;   // start of the long receiver hold-off
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_LIMIT      = 50000;
  localparam int TAIL_CYCLES      = 10;   // well past the result latency
  localparam int TIMEOUT_NS       = 1000000;

  logic clk = 1'b0;
  logic rst_n;

  orw_in_if  in_if ();
  orw_out_if out_if ();

  operand_read_write_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #1 clk = ~clk;

  // Accesses waiting to be driven, results waiting to come out
  in_item_t access_queue[$];
  result_t  due_results[$];

  int phase          = PH_NONE;
  int fail_count     = 0;
  int accepted_items = 0;

  // Shadow of the register file and condition codes
  logic [31:0] dreg_q [8];
  logic [31:0] areg_q [8];
  logic        n_flag;
  logic        z_flag;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Flags are captured after the access has updated them
  function automatic void push_result(kind_t k, logic [23:0] addr, logic [15:0] data,
                                      logic [31:0] rv, logic [3:0] cyc, logic fin);
    result_t r;
    r.kind        = k;
    r.bus_address = addr;
    r.bus_data    = data;
    r.read_value  = rv;
    r.cycles      = cyc;
    r.flag_n      = n_flag;
    r.flag_z      = z_flag;
    r.last        = fin;
    due_results.push_back(r);
  endfunction

  function automatic void set_flags(logic [31:0] v, logic [31:0] sign);
    n_flag = (v & sign) != 0;
    z_flag = (v == 0);
  endfunction

  // Only post-increment steps the address register; byte on SP steps by 2
  function automatic void advance_areg(logic [3:0] mode, logic [2:0] r, logic [1:0] sz);
    logic [31:0] step;
    if (mode != MODE_POSTINC) return;
    if (sz == SZ_LONG)      step = 32'd4;
    else if (sz == SZ_WORD) step = 32'd2;
    else                    step = (r == REG_SP) ? 32'd2 : 32'd1;
    areg_q[r] = (areg_q[r] + step) & ADDR_MASK;
  endfunction

  function automatic void predict_access(in_item_t it);
    logic [31:0] rv;
    logic [3:0]  cyc;
    logic [31:0] val;
    logic        mem_mode;
    logic        upd_flags;
    val       = it.store_value;
    mem_mode  = it.operand_mode == MODE_IND  || it.operand_mode == MODE_POSTINC ||
                it.operand_mode == MODE_DISP || it.operand_mode == MODE_ABSL;
    upd_flags = it.operand_mode != MODE_ABSL;

    // Unsupported: predecrement, other/undefined modes, immediate store, size 3
    if (it.op_size > SZ_LONG || it.operand_mode == MODE_PREDEC ||
        it.operand_mode >= MODE_OTHER ||
        (it.action == ACT_WRITE && it.operand_mode == MODE_IMM)) begin
      push_result(KIND_UNSUP, '0, '0, '0, CYC_NONE, 1'b1);
      return;
    end

    if (it.action == ACT_READ) begin
      cyc = CYC_NONE;
      if (it.operand_mode == MODE_DREG)      rv = dreg_q[it.reg_index];
      else if (it.operand_mode == MODE_AREG) rv = areg_q[it.reg_index];
      else if (it.operand_mode == MODE_IMM)  rv = it.immediate;
      else begin
        cyc = CYC_MEM;
        if (it.op_size == SZ_BYTE)      rv = {24'd0, it.mem_first[7:0]};
        else if (it.op_size == SZ_WORD) rv = {16'd0, it.mem_first};
        else begin
          rv  = {it.mem_first, it.mem_second};
          cyc = CYC_MEM_LONG;
        end
        advance_areg(it.operand_mode, it.reg_index, it.op_size);
      end
      push_result(KIND_VALUE, '0, '0, rv, cyc, 1'b1);
      return;
    end

    if (it.operand_mode == MODE_DREG) begin
      // Byte and word stores merge into the old register
      if (it.op_size == SZ_LONG) begin
        set_flags(val, 32'h8000_0000);
        dreg_q[it.reg_index] = val;
      end else if (it.op_size == SZ_WORD) begin
        set_flags({16'd0, val[15:0]}, 32'h0000_8000);
        dreg_q[it.reg_index][15:0] = val[15:0];
      end else begin
        set_flags({24'd0, val[7:0]}, 32'h0000_0080);
        dreg_q[it.reg_index][7:0] = val[7:0];
      end
      push_result(KIND_REG_DONE, '0, '0, '0, CYC_NONE, 1'b1);
    end else if (it.operand_mode == MODE_AREG) begin
      // Word sign-extends, byte leaves the register alone; flags untouched
      if (it.op_size == SZ_LONG)      areg_q[it.reg_index] = val;
      else if (it.op_size == SZ_WORD) areg_q[it.reg_index] = {{16{val[15]}}, val[15:0]};
      push_result(KIND_REG_DONE, '0, '0, '0, CYC_NONE, 1'b1);
    end else if (mem_mode) begin
      if (it.op_size == SZ_BYTE) begin
        if (upd_flags) set_flags({24'd0, val[7:0]}, 32'h0000_0080);
        advance_areg(it.operand_mode, it.reg_index, it.op_size);
        push_result(KIND_BUS_BYTE, it.eff_address, {8'd0, val[7:0]}, '0, CYC_MEM, 1'b1);
      end else if (it.op_size == SZ_WORD) begin
        if (upd_flags) set_flags({16'd0, val[15:0]}, 32'h0000_8000);
        advance_areg(it.operand_mode, it.reg_index, it.op_size);
        push_result(KIND_BUS_WORD, it.eff_address, val[15:0], '0, CYC_MEM, 1'b1);
      end else begin
        // Long store: high word first, second address wraps in 24 bits
        if (upd_flags) set_flags(val, 32'h8000_0000);
        advance_areg(it.operand_mode, it.reg_index, it.op_size);
        push_result(KIND_BUS_WORD, it.eff_address, val[31:16], '0, CYC_MEM_LONG, 1'b0);
        push_result(KIND_BUS_WORD, it.eff_address + 24'd2, val[15:0], '0, CYC_MEM_LONG,
                    1'b1);
      end
    end else begin
      push_result(KIND_UNSUP, '0, '0, '0, CYC_NONE, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_access(logic act, logic [3:0] mode, logic [2:0] r,
                                           logic [1:0] sz, logic [23:0] ea,
                                           logic [31:0] imm, logic [31:0] val,
                                           logic [15:0] m1, logic [15:0] m2);
    in_item_t it;
    it.action       = act;
    it.operand_mode = mode;
    it.reg_index    = r;
    it.op_size      = sz;
    it.eff_address  = ea;
    it.immediate    = imm;
    it.store_value  = val;
    it.mem_first    = m1;
    it.mem_second   = m2;
    return it;
  endfunction

  // Corner values: zero results, sign bits at every size, near-wrap addresses
  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0080;
      2: return 32'h0000_8000;
      3: return 32'h8000_0000;
      4: return 32'hffff_ffff;
      5: return 32'h00ff_fffe;
      6: return 32'h00ff_ffff;
      default: return 32'h1234_0000;
    endcase
  endfunction

  // Mostly supported accesses with random content, some unsupported noise
  function automatic in_item_t rand_access();
    in_item_t it;
    it.action       = 1'($urandom_range(0, 1));
    it.operand_mode = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 7))
                                                   : 4'($urandom_range(8, 15));
    it.reg_index    = 3'($urandom_range(0, 7));
    it.op_size      = ($urandom_range(0, 99) < 95) ? 2'($urandom_range(0, 2)) : 2'd3;
    it.eff_address  = ($urandom_range(0, 99) < 10) ?
                      24'(32'h00ff_ffff - $urandom_range(0, 3)) : 24'($urandom);
    it.immediate    = $urandom;
    it.store_value  = ($urandom_range(0, 99) < 25) ? corner_value() : $urandom;
    it.mem_first    = 16'($urandom);
    it.mem_second   = 16'($urandom);
    return it;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Wait at negedges, where everything has settled, until the block is idle
  task automatic wait_drained();
    int n;
    n = 0;
    while ((access_queue.size() != 0 || in_if.valid || due_results.size() != 0) &&
           n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: holds valid until the transaction is taken, then pulls the next
  // access from the queue unless the current phase calls for a gap
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t nxt;
    logic     gap;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      gap = (phase == PH_SENDER && $urandom_range(0, 99) < SENDER_IDLE_PCT) ||
            (phase == PH_BOTH   && $urandom_range(0, 99) < BOTH_IDLE_PCT);
      if (access_queue.size() != 0 && !gap) begin
        nxt = access_queue.pop_front();
        in_if.action       <= nxt.action;
        in_if.operand_mode <= nxt.operand_mode;
        in_if.reg_index    <= nxt.reg_index;
        in_if.op_size      <= nxt.op_size;
        in_if.eff_address  <= nxt.eff_address;
        in_if.immediate    <= nxt.immediate;
        in_if.store_value  <= nxt.store_value;
        in_if.mem_first    <= nxt.mem_first;
        in_if.mem_second   <= nxt.mem_second;
        in_if.valid        <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls per phase, plus one long hold-off in the
  // no-idle phase so the result path backs up into the input channel
  // ---------------------------------------------------------------------------
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    logic stall;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && phase == PH_NONE && accepted_items >= HOLD_AFTER_ITEMS) begin
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      stall = (phase == PH_RECEIVER && $urandom_range(0, 99) < RECEIVER_IDLE_PCT) ||
              (phase == PH_BOTH     && $urandom_range(0, 99) < BOTH_IDLE_PCT);
      out_if.ready <= !stall;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transaction, compare each result
  // transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t seen;
    result_t  want;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        dreg_q[i] = '0;
        areg_q[i] = '0;
      end
      n_flag = 1'b0;
      z_flag = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        seen = make_access(in_if.action, in_if.operand_mode, in_if.reg_index,
                           in_if.op_size, in_if.eff_address, in_if.immediate,
                           in_if.store_value, in_if.mem_first, in_if.mem_second);
        predict_access(seen);
        accepted_items <= accepted_items + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with nothing expected: kind %0d", out_if.kind);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind",        32'(want.kind),        32'(out_if.kind));
          check_field("bus_address", 32'(want.bus_address), 32'(out_if.bus_address));
          check_field("bus_data",    32'(want.bus_data),    32'(out_if.bus_data));
          check_field("read_value",  want.read_value,       out_if.read_value);
          check_field("cycles",      32'(want.cycles),      32'(out_if.cycles));
          check_field("flag_n",      32'(want.flag_n),      32'(out_if.flag_n));
          check_field("flag_z",      32'(want.flag_z),      32'(out_if.flag_z));
          check_field("last",        32'(want.last),        32'(out_if.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed accesses, then one random batch per idle phase
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid        = 1'b0;
    in_if.action       = ACT_READ;
    in_if.operand_mode = MODE_DREG;
    in_if.reg_index    = '0;
    in_if.op_size      = SZ_BYTE;
    in_if.eff_address  = '0;
    in_if.immediate    = '0;
    in_if.store_value  = '0;
    in_if.mem_first    = '0;
    in_if.mem_second   = '0;
    out_if.ready       = 1'b0;
    rst_n              = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Register file: full read regardless of size, merges, flags at each size
    access_queue.push_back(make_access(ACT_READ,  MODE_DREG, 3'd0, SZ_BYTE, '0, '0, '0,
                                       '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_DREG, 3'd3, SZ_LONG, '0, '0,
                                       32'h8000_0000, '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_DREG, 3'd3, SZ_WORD, '0, '0,
                                       32'hffff_0000, '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_DREG, 3'd3, SZ_BYTE, '0, '0,
                                       32'h0000_00ff, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_DREG, 3'd3, SZ_BYTE, '0, '0, '0,
                                       '0, '0));
    // Address register: word sign-extension both ways, byte store ignored
    access_queue.push_back(make_access(ACT_WRITE, MODE_AREG, 3'd2, SZ_WORD, '0, '0,
                                       32'h0000_8000, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_AREG, 3'd2, SZ_WORD, '0, '0, '0,
                                       '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_AREG, 3'd2, SZ_WORD, '0, '0,
                                       32'hffff_7fff, '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_AREG, 3'd2, SZ_BYTE, '0, '0,
                                       32'h0000_00ab, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_AREG, 3'd2, SZ_LONG, '0, '0, '0,
                                       '0, '0));
    // Post-increment masks to the address width; byte on SP steps by two
    access_queue.push_back(make_access(ACT_WRITE, MODE_AREG, 3'd5, SZ_LONG, '0, '0,
                                       32'hffff_ffff, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_POSTINC, 3'd5, SZ_LONG, 24'h10, '0,
                                       '0, 16'hffff, 16'h0000));
    access_queue.push_back(make_access(ACT_READ,  MODE_AREG, 3'd5, SZ_LONG, '0, '0, '0,
                                       '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_AREG, REG_SP, SZ_LONG, '0, '0,
                                       32'h00ff_ffff, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_POSTINC, REG_SP, SZ_BYTE, '0, '0,
                                       '0, 16'h12ff, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_POSTINC, REG_SP, SZ_BYTE,
                                       24'h000001, '0, 32'h0000_0000, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_AREG, REG_SP, SZ_LONG, '0, '0, '0,
                                       '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_POSTINC, 3'd1, SZ_BYTE, 24'h000100,
                                       '0, 32'h0000_0080, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_AREG, 3'd1, SZ_WORD, '0, '0, '0,
                                       '0, '0));
    // Immediate, memory reads at each size
    access_queue.push_back(make_access(ACT_READ,  MODE_IMM, 3'd0, SZ_LONG, '0,
                                       32'hffff_ffff, '0, '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_IND, 3'd4, SZ_LONG, 24'hffffff, '0,
                                       '0, 16'h8000, 16'hffff));
    access_queue.push_back(make_access(ACT_READ,  MODE_DISP, 3'd6, SZ_BYTE, 24'h000000, '0,
                                       '0, 16'habcd, 16'h1234));
    access_queue.push_back(make_access(ACT_READ,  MODE_ABSL, 3'd0, SZ_WORD, 24'h800000, '0,
                                       '0, 16'hffff, '0));
    // Long stores: address wrap on the second word; absolute long keeps flags
    access_queue.push_back(make_access(ACT_WRITE, MODE_DISP, 3'd0, SZ_LONG, 24'hfffffe, '0,
                                       32'h0000_0000, '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_ABSL, 3'd0, SZ_LONG, 24'hffffff, '0,
                                       32'hdead_beef, '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, MODE_IND, 3'd0, SZ_WORD, 24'h123456, '0,
                                       32'h0000_8000, '0, '0));
    // Unsupported: immediate destination, predecrement, other mode, size 3
    access_queue.push_back(make_access(ACT_WRITE, MODE_IMM, 3'd0, SZ_WORD, '0, '0, 32'd1,
                                       '0, '0));
    access_queue.push_back(make_access(ACT_READ,  MODE_PREDEC, 3'd3, SZ_LONG, '0, '0, '0,
                                       '0, '0));
    access_queue.push_back(make_access(ACT_WRITE, 4'd15, 3'd7, 2'd3, '0, '0, '0, '0, '0));
    wait_drained();

    for (int p = PH_NONE; p <= PH_BOTH; p++) begin
      phase = p;
      repeat (RANDOM_PER_PHASE) access_queue.push_back(rand_access());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected result transactions never arrived", due_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("operand_read_write_unit_tb OK");
    end else begin
      $display("operand_read_write_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("operand_read_write_unit_tb NOT OK");
    $finish;
  end

endmodule
